### design/dssw_pkg.sv
// shared types, microcode program and glyph table for the seven-segment number writer
package dssw_pkg;

  localparam int MAX_BOX   = 16;
  localparam int BOX_W     = $clog2(MAX_BOX + 1);
  localparam int MAX_DIGITS = 5;
  localparam int ND_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W    = $clog2(MAX_DIGITS);
  localparam int LEN_W     = $clog2(MAX_DIGITS + 2);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // display modes
  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_TWO_DIG  = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // glyph codes beyond the decimal digits
  localparam logic [3:0] GLYPH_BLANK = 4'd10;
  localparam logic [3:0] GLYPH_MINUS = 4'd11;

  // reciprocal of ten for 16-bit dividends: q = (x * RECIP10) >> RECIP_SHIFT
  localparam logic [15:0] RECIP10     = 16'hCCCD;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    COND_NEVER      = 2'd0,
    COND_STAY_IDLE  = 2'd1,
    COND_MORE_DIGIT = 2'd2,
    COND_EMIT_MORE  = 2'd3
  } cond_t;

  typedef logic [1:0] pc_t;

  typedef struct packed {
    logic  in_rdy;
    logic  div;
    logic  prep;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t STEP_WAIT = 2'd0;
  localparam pc_t STEP_DIV  = 2'd1;
  localparam pc_t STEP_PREP = 2'd2;
  localparam pc_t STEP_EMIT = 2'd3;

  // taken jump goes to target, otherwise pc + 1 (the emit step wraps to wait)
  localparam ucode_t UCODE [4] = '{
    '{in_rdy: 1'b1, div: 1'b0, prep: 1'b0, emit: 1'b0, cond: COND_STAY_IDLE,
      target: STEP_WAIT},
    '{in_rdy: 1'b0, div: 1'b1, prep: 1'b0, emit: 1'b0, cond: COND_MORE_DIGIT,
      target: STEP_DIV},
    '{in_rdy: 1'b0, div: 1'b0, prep: 1'b1, emit: 1'b0, cond: COND_NEVER,
      target: STEP_WAIT},
    '{in_rdy: 1'b0, div: 1'b0, prep: 1'b0, emit: 1'b1, cond: COND_EMIT_MORE,
      target: STEP_EMIT}
  };

  function automatic logic [7:0] seg_of(input logic [3:0] g);
    logic [7:0] s;
    case (g)
      4'd0:        s = 8'b0011_1111;
      4'd1:        s = 8'b0000_0110;
      4'd2:        s = 8'b0101_1011;
      4'd3:        s = 8'b0100_1111;
      4'd4:        s = 8'b0110_0110;
      4'd5:        s = 8'b0110_1101;
      4'd6:        s = 8'b0111_1101;
      4'd7:        s = 8'b0000_0111;
      4'd8:        s = 8'b0111_1111;
      4'd9:        s = 8'b0110_1111;
      GLYPH_MINUS: s = 8'b0100_0000;
      default:     s = 8'b0000_0000;
    endcase
    return s;
  endfunction

endpackage

### design/decimal_to_seven_segment_writer.sv
// seven-segment number writer: microcoded sequencer with divide-by-ten datapath
//
// Accepts one number per transaction and writes it as seven-segment patterns, one
// output transaction per display position in ascending order from start_position
// (positions wrap at 256), tlast marking the final pattern. Mode 0 shows an unsigned
// 16-bit value, mode 1 a signed one with a leading minus, both without leading zeros
// and padded with blanks to |box_width| (saturated at 16; negative width pads on the
// right, positive on the left). Mode 2 shows two digits clamped to 99 with a blanked
// leading zero; action 3 is consumed and produces nothing. An item passes an accept
// step, a divide step per decimal digit (1 to 5, always 2 in mode 2) through the shared
// reciprocal multiplier, a setup step, and then an emit step per pattern, max(text
// length, |box|) of them, stretched by any output back-pressure. The output register
// lets the next item be accepted while the last pattern still waits.
module decimal_to_seven_segment_writer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // action[1:0], value[18:2], start_position[26:19], box_width[32:27], zero fill
  input  logic [dssw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // digit_position[7:0], segment_pattern[15:8]
  output logic [dssw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import dssw_pkg::*;

  // input fields
  logic [1:0]  in_action;
  logic [16:0] in_value;
  logic [7:0]  in_start;
  logic [5:0]  in_box;

  assign in_action = s_axis_tdata[1:0];
  assign in_value  = s_axis_tdata[18:2];
  assign in_start  = s_axis_tdata[26:19];
  assign in_box    = s_axis_tdata[32:27];

  // sequencer
  pc_t    pc;
  pc_t    pc_next;
  ucode_t uw;
  logic   jump;

  // datapath registers
  logic [1:0]        mode;
  logic [15:0]       mag;
  logic              neg;
  logic              left;
  logic [7:0]        start;
  logic [BOX_W-1:0]  absb;
  logic [3:0]        rev [MAX_DIGITS];
  logic [ND_W-1:0]   nd;
  logic [LEN_W-1:0]  len;
  logic [BOX_W-1:0]  total;
  logic [BOX_W-1:0]  pad;
  logic [BOX_W-1:0]  idx;

  // output register
  logic [7:0] out_pos;
  logic [7:0] out_seg;
  logic       out_last;
  logic       out_valid;

  logic in_fire;
  logic emit_fire;
  logic out_free;

  assign uw            = UCODE[pc];
  assign s_axis_tready = uw.in_rdy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign emit_fire     = uw.emit && out_free;

  // load-time operand shaping
  logic [15:0] load_mag;
  logic        load_neg;
  logic        load_left;
  logic [6:0]  box_mag;
  logic [BOX_W-1:0] load_absb;

  always_comb begin
    load_neg  = 1'b0;
    load_left = 1'b0;
    load_absb = '0;
    box_mag   = in_box[5] ? (7'd64 - {1'b0, in_box}) : {1'b0, in_box};
    if (in_action == MODE_TWO_DIG) begin
      // clamp to two digits
      load_mag = (in_value[7:0] >= 8'd100) ? 16'd99 : {8'd0, in_value[7:0]};
    end else begin
      load_mag  = in_value[15:0];
      load_left = in_box[5];
      if (in_action == MODE_SIGNED && in_value[15]) begin
        load_neg = 1'b1;
        load_mag = 16'd0 - in_value[15:0];  // 0x8000 stays 32768
      end
      if (box_mag > 7'(MAX_BOX)) begin
        load_absb = BOX_W'(MAX_BOX);
      end else begin
        load_absb = box_mag[BOX_W-1:0];
      end
    end
  end

  // one decimal digit per step through the reciprocal multiplier
  logic [31:0] prod;
  logic [15:0] quo;
  logic [3:0]  rem;
  logic [ND_W-1:0] nd_inc;
  logic        more_digits;

  assign prod   = mag * RECIP10;
  assign quo    = 16'(prod >> RECIP_SHIFT);
  assign rem    = 4'(mag - ((quo << 3) + (quo << 1)));
  assign nd_inc = nd + 1'b1;

  always_comb begin
    if (mode == MODE_TWO_DIG) begin
      more_digits = nd_inc < ND_W'(2);
    end else begin
      more_digits = (quo != 16'd0) && (nd_inc < ND_W'(MAX_DIGITS));
    end
  end

  // text length and padding
  logic [LEN_W-1:0] prep_len;
  logic [BOX_W-1:0] prep_len_w;

  assign prep_len   = LEN_W'(nd) + LEN_W'(neg);
  assign prep_len_w = BOX_W'(prep_len);

  // glyph selection for the current emit index
  logic             is_text;
  logic [BOX_W-1:0] tpos;
  logic [DIDX_W:0]  didx;
  logic [3:0]       digit;
  logic [3:0]       glyph;

  always_comb begin
    if (left) begin
      is_text = idx < BOX_W'(len);
      tpos    = idx;
    end else begin
      is_text = idx >= pad;
      tpos    = idx - pad;
    end
    // text position j maps to stored digit nd - 1 - j + neg
    didx  = (DIDX_W + 1)'(nd) - 1'b1 - (DIDX_W + 1)'(tpos) + (DIDX_W + 1)'(neg);
    digit = (didx < (DIDX_W + 1)'(MAX_DIGITS)) ? rev[didx[DIDX_W-1:0]] : GLYPH_BLANK;
    if (!is_text) begin
      glyph = GLYPH_BLANK;
    end else if (neg && tpos == '0) begin
      glyph = GLYPH_MINUS;
    end else if (mode == MODE_TWO_DIG && tpos == '0 && digit == 4'd0) begin
      glyph = GLYPH_BLANK;  // leading zero of the two-digit field
    end else begin
      glyph = digit;
    end
  end

  // jump condition and next step
  always_comb begin
    case (uw.cond)
      COND_NEVER:      jump = 1'b0;
      COND_STAY_IDLE:  jump = !in_fire || in_action == MODE_UNUSED;
      COND_MORE_DIGIT: jump = more_digits;
      COND_EMIT_MORE:  jump = !emit_fire || idx != total - 1'b1;
      default:         jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode  <= in_action;
      mag   <= load_mag;
      neg   <= load_neg;
      left  <= load_left;
      start <= in_start;
      absb  <= load_absb;
      nd    <= '0;
    end
    if (uw.div) begin
      rev[nd[DIDX_W-1:0]] <= rem;
      mag <= quo;
      nd  <= nd_inc;
    end
    if (uw.prep) begin
      len <= prep_len;
      idx <= '0;
      if (prep_len_w >= absb) begin
        total <= prep_len_w;
        pad   <= '0;
      end else begin
        total <= absb;
        pad   <= absb - prep_len_w;
      end
    end
    if (emit_fire) begin
      idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_pos  <= start + 8'(idx);
      out_seg  <= seg_of(glyph);
      out_last <= idx == total - 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_seg, out_pos};
  assign m_axis_tlast  = out_last;

  // checks
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    uw.div |-> nd < ND_W'(MAX_DIGITS))
    else $error("digit store overrun");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    uw.emit |-> idx < total)
    else $error("emit index past run length");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    emit_fire && idx == total - 1'b1 |=> pc == STEP_WAIT && m_axis_tvalid && m_axis_tlast)
    else $error("final pattern did not end the run");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_action != MODE_UNUSED |=> pc == STEP_DIV)
    else $error("accepted item did not start conversion");

endmodule

### sim/testbench.sv
// self-checking testbench for the seven-segment number writer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dssw_pkg::*;

  // one input transaction, packed from the lowest bit up as the block expects
  typedef struct packed {
    logic signed [5:0]  width;
    logic [7:0]         start;
    logic signed [16:0] value;
    logic [1:0]         action;
  } number_item_t;

  // one display pattern as it should leave the block
  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] seg;
    logic       last;
  } pattern_t;

  // directed row: patterns typed in where obvious, otherwise left to the predictor
  typedef struct packed {
    logic [1:0]         action;
    logic signed [16:0] value;
    logic [7:0]         start;
    logic signed [5:0]  width;
    logic signed [7:0]  seg_count;
    logic [47:0]        segs;      // first pattern in the lowest byte
  } number_row_t;

  localparam logic signed [7:0] FROM_PREDICTOR = -8'sd1;
  localparam int NUM_ROWS      = 25;
  localparam int RANDOM_ITEMS  = 300;
  localparam int QUIET_ITEMS   = 40;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 64;

  // segment patterns indexed by glyph code: digits, then blank and minus
  localparam logic [7:0] GLYPH_SEGS [12] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00, 8'h40
  };

  // extremes, every mode, zero, clamping, box handling, wrap and the unused mode
  localparam number_row_t NUMBER_ROWS [NUM_ROWS] = '{
    '{MODE_UNSIGNED, 17'sd0,      8'd0,   6'sd0,   8'sd1,  48'h3F},
    '{MODE_UNSIGNED, 17'sd65535,  8'd10,  6'sd0,   8'sd5,  48'h6D_4F_6D_6D_7D},
    '{MODE_SIGNED,   -17'sd32768, 8'd20,  6'sd0,   8'sd6,  48'h7F_7D_07_5B_4F_40},
    '{MODE_SIGNED,   -17'sd1,     8'd30,  6'sd0,   8'sd2,  48'h06_40},
    '{MODE_SIGNED,   17'sd32767,  8'd40,  6'sd0,   FROM_PREDICTOR, 48'h0},
    '{MODE_SIGNED,   17'sd0,      8'd50,  6'sd0,   8'sd1,  48'h3F},
    '{MODE_TWO_DIG,  17'sd0,      8'd60,  6'sd0,   8'sd2,  48'h3F_00},
    '{MODE_TWO_DIG,  17'sd99,     8'd62,  6'sd0,   8'sd2,  48'h6F_6F},
    '{MODE_TWO_DIG,  17'sd100,    8'd64,  -6'sd16, 8'sd2,  48'h6F_6F},
    '{MODE_TWO_DIG,  17'sd255,    8'd66,  6'sd16,  8'sd2,  48'h6F_6F},
    '{MODE_TWO_DIG,  17'sd9,      8'd68,  6'sd5,   8'sd2,  48'h6F_00},
    '{MODE_TWO_DIG,  17'sd10,     8'd70,  6'sd0,   8'sd2,  48'h3F_06},
    '{MODE_UNUSED,   17'sd12345,  8'd72,  6'sd16,  8'sd0,  48'h0},
    '{MODE_UNSIGNED, 17'sd7,      8'd80,  6'sd16,  FROM_PREDICTOR, 48'h0},
    '{MODE_UNSIGNED, 17'sd7,      8'd100, -6'sd16, FROM_PREDICTOR, 48'h0},
    '{MODE_SIGNED,   -17'sd32768, 8'd120, -6'sd16, FROM_PREDICTOR, 48'h0},
    '{MODE_SIGNED,   -17'sd32768, 8'd140, 6'sd16,  FROM_PREDICTOR, 48'h0},
    '{MODE_UNSIGNED, 17'sd12345,  8'd160, 6'sd5,   FROM_PREDICTOR, 48'h0},
    '{MODE_UNSIGNED, 17'sd12345,  8'd170, 6'sd3,   FROM_PREDICTOR, 48'h0},
    '{MODE_SIGNED,   -17'sd42,    8'd180, -6'sd6,  FROM_PREDICTOR, 48'h0},
    '{MODE_UNSIGNED, 17'sd65535,  8'd252, 6'sd8,   FROM_PREDICTOR, 48'h0},
    '{MODE_TWO_DIG,  17'sd57,     8'd255, 6'sd0,   8'sd2,  48'h07_6D},
    '{MODE_SIGNED,   17'sd1234,   8'd250, -6'sd10, FROM_PREDICTOR, 48'h0},
    '{MODE_UNUSED,   -17'sd1,     8'd255, -6'sd16, 8'sd0,  48'h0},
    '{MODE_TWO_DIG,  -17'sd1,     8'd0,   6'sd0,   8'sd2,  48'h6F_6F}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // action[1:0], value[18:2], start_position[26:19], box_width[32:27], zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  // digit_position[7:0], segment_pattern[15:8]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  pattern_t pending_patterns [$];
  pattern_t oldest_pattern;
  int       error_count = 0;
  int       patterns_checked = 0;
  int       numbers_accepted = 0;
  int       mode_count [4] = '{0, 0, 0, 0};
  int       input_stall_cycles = 0;
  int       send_calm = 0;
  bit       quiet_tail = 1'b0;
  bit       long_hold_done = 1'b0;

  decimal_to_seven_segment_writer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout at %0t with %0d patterns outstanding", $time, pending_patterns.size());
    $display("Verification failed");
    $finish;
  end

  // work out the glyph sequence for one number and queue its patterns
  function automatic void predict_patterns(input number_item_t it);
    int  glyph_seq [$];
    int  text [$];
    int  mag;
    int  n;
    int  w;
    int  box;
    int  pad;
    bit  neg;
    pattern_t p;
    if (it.action == MODE_TWO_DIG) begin
      n = it.value[7:0];
      if (n >= 100) begin
        // clamp anything three digits wide to 99
        glyph_seq.push_back(9);
        glyph_seq.push_back(9);
      end else begin
        glyph_seq.push_back((n / 10 == 0) ? int'(GLYPH_BLANK) : n / 10);
        glyph_seq.push_back(n % 10);
      end
    end else if (it.action != MODE_UNUSED) begin
      mag = it.value[15:0];
      neg = (it.action == MODE_SIGNED) && it.value[15];
      if (neg) mag = 65536 - mag;
      do begin
        text.push_front(mag % 10);
        mag = mag / 10;
      end while (mag != 0);
      if (neg) text.push_front(GLYPH_MINUS);
      w = it.width;
      box = (w < 0) ? -w : w;
      if (box > MAX_BOX) box = MAX_BOX;
      pad = box - text.size();
      if (pad < 0) pad = 0;
      // positive width pads in front, negative width pads behind
      if (w >= 0) repeat (pad) glyph_seq.push_back(GLYPH_BLANK);
      foreach (text[i]) glyph_seq.push_back(text[i]);
      if (w < 0) repeat (pad) glyph_seq.push_back(GLYPH_BLANK);
    end
    foreach (glyph_seq[i]) begin
      p.pos  = it.start + 8'(i);
      p.seg  = GLYPH_SEGS[glyph_seq[i]];
      p.last = (i == glyph_seq.size() - 1);
      pending_patterns.push_back(p);
    end
  endfunction

  // random number with a spread of digit counts, widths and positions
  function automatic number_item_t random_number();
    number_item_t it;
    int sel;
    int digits;
    int lo;
    int hi;
    int v;
    sel = $urandom_range(0, 99);
    it.action = (sel < 3) ? MODE_UNUSED : 2'(sel % 3);
    digits = $urandom_range(1, 5);
    lo = (digits == 1) ? 0 : 10 ** (digits - 1);
    hi = 10 ** digits - 1;
    case (it.action)
      MODE_UNSIGNED: begin
        if ($urandom_range(0, 9) == 0) begin
          sel = $urandom_range(0, 4);
          v = (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel == 2) ? 65534 :
              (sel == 3) ? 10000 : 9999;
        end else begin
          if (hi > 65535) hi = 65535;
          v = $urandom_range(lo, hi);
        end
      end
      MODE_SIGNED: begin
        if ($urandom_range(0, 19) == 0) begin
          v = $urandom_range(0, 1) ? -32768 : 32767;
        end else begin
          if (hi > 32767) hi = 32767;
          if (lo > hi) lo = 10000;
          v = $urandom_range(lo, hi);
          if ($urandom_range(0, 1)) v = -v;
        end
      end
      MODE_TWO_DIG: begin
        if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 98303)) - 32768;
        else v = $urandom_range(0, 255);
      end
      default: v = int'($urandom_range(0, 98303)) - 32768;
    endcase
    it.value = v[16:0];
    it.start = $urandom_range(0, 255);
    it.width = 6'(int'($urandom_range(0, 32)) - 16);
    return it;
  endfunction

  // hand one number to the block, then queue what it must produce
  task automatic offer_number(input number_item_t it, input logic signed [7:0] seg_count,
                              input logic [47:0] segs);
    int gap;
    pattern_t p;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {{(IN_TDATA_W - $bits(number_item_t)){1'b0}}, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    numbers_accepted++;
    mode_count[it.action]++;
    if (seg_count == FROM_PREDICTOR) begin
      predict_patterns(it);
    end else begin
      for (int i = 0; i < seg_count; i++) begin
        p.pos  = it.start + 8'(i);
        p.seg  = segs[8*i +: 8];
        p.last = (i == seg_count - 1);
        pending_patterns.push_back(p);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // output side: compare every pattern against the oldest expectation
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_patterns.size() == 0) begin
        error_count++;
        $display("%0t: unexpected pattern, expected none, got pos %h seg %h last %b",
                 $time, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
      end else begin
        oldest_pattern = pending_patterns.pop_front();
        patterns_checked++;
        check_field("digit_position", oldest_pattern.pos, m_axis_tdata[7:0]);
        check_field("segment_pattern", oldest_pattern.seg, m_axis_tdata[15:8]);
        check_field("last_of_run", {7'd0, oldest_pattern.last}, {7'd0, m_axis_tlast});
      end
    end
  end

  // receiver: random back-pressure bursts, one long hold-off to fill the block
  initial begin
    int calm;
    calm = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!long_hold_done && numbers_accepted >= 40) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (calm > 0) begin
        calm--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) calm = $urandom_range(20, 80);
      end
    end
  end

  // sender: reset, directed table, random numbers, drain, verdict
  initial begin
    number_item_t it;
    int shown;
    shown = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      it.action = NUMBER_ROWS[r].action;
      it.value  = NUMBER_ROWS[r].value;
      it.start  = NUMBER_ROWS[r].start;
      it.width  = NUMBER_ROWS[r].width;
      offer_number(it, NUMBER_ROWS[r].seg_count, NUMBER_ROWS[r].segs);
    end

    // ignored numbers do not count toward the random total
    while (shown < RANDOM_ITEMS) begin
      it = random_number();
      if (it.action != MODE_UNUSED) shown++;
      quiet_tail = (shown > RANDOM_ITEMS - QUIET_ITEMS);
      offer_number(it, FROM_PREDICTOR, 48'h0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_patterns.size() != 0) @(posedge clk);
    // room for a trailing ignored number and any stray output
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("numbers: %0d unsigned, %0d signed, %0d two-digit, %0d ignored",
             mode_count[MODE_UNSIGNED], mode_count[MODE_SIGNED],
             mode_count[MODE_TWO_DIG], mode_count[MODE_UNUSED]);
    $display("%0d patterns compared, input held back for %0d cycles",
             patterns_checked, input_stall_cycles);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
